// ===== design/deq_pkg.sv =====
// Shared types, sizes and conversion helpers for the double-ended queue.
`default_nettype none

package deq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Offsets cover both a fill value and a 4-bit position.
  localparam int OFF_W  = (CNT_W > 4) ? CNT_W : 4;
  localparam int SUM_W  = OFF_W + 1;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Memory access and result bookkeeping for one item.
  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    status_t           status;
    logic              use_rd;
    logic [CNT_W-1:0]  count;
  } ctrl_t;

  function automatic logic [WORD_BITS-1:0] word_from_field(input logic [VALUE_W-1:0] v);
    logic [63+VALUE_W:0] t;
    t = (64 + VALUE_W)'(v);
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] field_from_word(input logic [WORD_BITS-1:0] w);
    logic [63+VALUE_W:0] t;
    t = (64 + VALUE_W)'(w);
    return t[VALUE_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] t;
    t = (CNT_W + COUNT_W)'(c);
    return t[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/deq_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/deq_ctrl.sv =====
// Head and fill pointers, operation decode and ring address generation.
`default_nettype none

module deq_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [2:0]                op,
  input  wire logic [deq_pkg::POS_W-1:0] position,
  output deq_pkg::ctrl_t                 ctrl
);
  import deq_pkg::*;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] head_inc, head_dec, ring_addr;
  logic [OFF_W-1:0]  off;
  logic [SUM_W-1:0]  sum;
  logic              full, empty, front_push, we, re;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign head_inc = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;

  // head + offset modulo DEPTH; offset stays below DEPTH on every used path
  assign sum       = SUM_W'(head_r) + SUM_W'(off);
  assign ring_addr = (sum >= SUM_W'(DEPTH)) ? ADDR_W'(sum - SUM_W'(DEPTH)) : ADDR_W'(sum);

  always_comb begin
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    off         = '0;
    front_push  = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    ctrl.status = ST_OK;
    ctrl.use_rd = 1'b0;
    unique case (op)
      OP_PUSH_BACK: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          off      = OFF_W'(fill_r);
          we       = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          ctrl.status = ST_FULL;
        end else begin
          front_push = 1'b1;
          we         = 1'b1;
          head_nxt   = head_dec;
          fill_nxt   = fill_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          off         = OFF_W'(fill_r - 1'b1);
          re          = 1'b1;
          ctrl.use_rd = 1'b1;
          fill_nxt    = fill_r - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          ctrl.status = ST_EMPTY;
        end else begin
          re          = 1'b1;
          ctrl.use_rd = 1'b1;
          head_nxt    = head_inc;
          fill_nxt    = fill_r - 1'b1;
        end
      end
      OP_READ: begin
        if (OFF_W'(position) >= OFF_W'(fill_r)) begin
          ctrl.status = ST_RANGE;
        end else begin
          off         = OFF_W'(position);
          re          = 1'b1;
          ctrl.use_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ctrl.mem_we   = acc & we;
    ctrl.mem_re   = acc & re;
    ctrl.mem_addr = front_push ? head_dec : ring_addr;
    ctrl.count    = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (acc) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill exceeds capacity");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.mem_we && ctrl.mem_re))
    else $error("read and write in one cycle");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !empty && (op == OP_POP_BACK || op == OP_POP_FRONT))
      |=> fill_r == $past(fill_r) - 1'b1)
    else $error("pop did not lower fill");

  a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_READ) |=> ($stable(head_r) && $stable(fill_r)))
    else $error("read changed pointers");

endmodule

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue: ring memory, pointer control and result stages.
`default_nettype none

// Double-ended queue of up to 16 words held in a ring inside one single-port
// RAM, addressed by a front (head) pointer and a fill count. Each input item
// carries one operation: push back, push front, pop back, pop front or read by
// position from the front; each item gives exactly one result item with a
// status, the popped or read word (zero otherwise) and the count after the
// operation. Rate: one item per clock while in_stall is low; a result passes
// through the RAM's registered read and then the output register. Pointers
// update at accept, so back-to-back items always see the previous item's
// effect; a write and a later read of the same entry fall in different
// cycles and need no forwarding. The RAM contents are not cleared at reset;
// only entries that were pushed are ever returned. in_stall rises only when
// both the result stage and the output register are full and the output is
// stalled.

module double_ended_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_op,
  input  wire logic [deq_pkg::VALUE_W-1:0] in_value,
  input  wire logic [deq_pkg::POS_W-1:0]   in_position,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_status,
  output logic [deq_pkg::VALUE_W-1:0]      out_data,
  output logic [deq_pkg::COUNT_W-1:0]      out_count
);
  import deq_pkg::*;

  ctrl_t                ctrl;
  logic                 in_acc;
  logic [WORD_BITS-1:0] rd_word;

  // RAM-read stage: waits for the registered read data
  logic                 s1_valid_r, s1_valid_nxt;
  status_t              s1_status_r;
  logic                 s1_use_rd_r;
  logic [CNT_W-1:0]     s1_count_r;
  logic                 s1_go;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r;
  logic [VALUE_W-1:0]   out_data_r;
  logic [COUNT_W-1:0]   out_count_r;

  assign s1_go    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~s1_go;
  assign in_acc   = in_valid & ~in_stall;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .op       (in_op),
    .position (in_position),
    .ctrl     (ctrl)
  );

  // Read data is held while the stage stalls: no new read issues then.
  deq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .re    (ctrl.mem_re),
    .addr  (ctrl.mem_addr),
    .wdata (word_from_field(in_value)),
    .rdata (rd_word)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r <= ctrl.status;
      s1_use_rd_r <= ctrl.use_rd;
      s1_count_r  <= ctrl.count;
    end
    if (s1_go) begin
      out_status_r <= s1_status_r;
      out_data_r   <= s1_use_rd_r ? field_from_word(rd_word) : '0;
      out_count_r  <= count_field(s1_count_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("held item dropped from read stage");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("item moved without reaching output");

endmodule

`default_nettype wire

// ===== test/tb_double_ended_queue.sv =====
// Self-checking testbench for the double-ended queue: directed corner items, then random traffic.
`default_nettype none

module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // op field values the block must treat as no-ops
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  localparam int RANDOM_ITEMS = 1080;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;      // margin after the last owed result to catch strays
  localparam int TIMEOUT_NS   = 6_000_000;

  typedef struct {
    status_t             status;
    logic [VALUE_W-1:0]  data;
    logic [COUNT_W-1:0]  count;
  } deq_result_t;

  // Random walk bias for the fill level, so full and empty are hit often.
  typedef enum {DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIXED} drift_t;

  // ---------------------------------------------------------------------------
  // Ring-buffer mirror of the queue plus the list of results still owed.
  // ---------------------------------------------------------------------------
  class deque_tracker;
    logic [WORD_BITS-1:0] ring [DEPTH];
    logic [ADDR_W-1:0]    head;
    logic [CNT_W-1:0]     fill;
    deq_result_t          owed_results [$];
    int errors, reported, n_items, n_checked;
    int n_full, n_empty, n_range, n_unknown, n_at_capacity;

    function new();
      head = '0;
      fill = '0;
    endfunction

    // Apply one accepted item and queue the result it must produce.
    function void apply_op(logic [2:0] op, logic [VALUE_W-1:0] value,
                           logic [POS_W-1:0] pos);
      deq_result_t       res;
      logic [ADDR_W-1:0] idx;
      res.status = ST_OK;
      res.data   = '0;
      n_items++;
      case (op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (fill >= DEPTH) begin
            res.status = ST_FULL;
            n_full++;
          end else begin
            if (op == OP_PUSH_BACK) begin
              idx = head + ADDR_W'(fill);
            end else begin
              head = head - 1'b1;
              idx  = head;
            end
            ring[idx] = value[WORD_BITS-1:0];
            fill++;
            if (fill == DEPTH) n_at_capacity++;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
            n_empty++;
          end else begin
            fill--;
            idx = head + ADDR_W'(fill);
            res.data = VALUE_W'(ring[idx]);
          end
        end
        OP_POP_FRONT: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
            n_empty++;
          end else begin
            res.data = VALUE_W'(ring[head]);
            head = head + 1'b1;
            fill--;
          end
        end
        OP_READ: begin
          if (CNT_W'(pos) >= fill) begin
            res.status = ST_RANGE;
            n_range++;
          end else begin
            idx = head + ADDR_W'(pos);
            res.data = VALUE_W'(ring[idx]);
          end
        end
        default: n_unknown++;
      endcase
      res.count = COUNT_W'(fill);
      owed_results.push_back(res);
    endfunction

    // Check one result handed over by the block against the oldest owed one.
    function void compare_result(logic [1:0] status, logic [VALUE_W-1:0] data,
                                 logic [COUNT_W-1:0] count);
      deq_result_t exp_res;
      if (owed_results.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: unexpected result status=%0d data=%h count=%0d",
                   $realtime, status, data, count);
        end
        return;
      end
      exp_res = owed_results.pop_front();
      n_checked++;
      if (status !== exp_res.status || data !== exp_res.data ||
          count !== exp_res.count) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: result %0d mismatch: status exp %0d got %0d, data exp %h got %h, count exp %0d got %0d",
                   $realtime, n_checked, exp_res.status, status, exp_res.data, data,
                   exp_res.count, count);
        end
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals; every block input starts at a known value.
  // ---------------------------------------------------------------------------
  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [2:0]         in_op       = 3'd0;
  logic [VALUE_W-1:0] in_value    = '0;
  logic [POS_W-1:0]   in_position = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [1:0]         out_status;
  logic [VALUE_W-1:0] out_data;
  logic [COUNT_W-1:0] out_count;

  bit in_calm = 1'b0;     // when set the sender runs back to back

  deque_tracker tracker = new();

  double_ended_queue u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_double_ended_queue failed");
    $finish;
  end

  // Idle length: mostly none, often a few cycles, now and then a long pause.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side backpressure. Reads happen at the edge, before the NBA update,
  // so the block and the monitor both see the same stall value.
  initial begin : result_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 24) == 0) begin
        out_stall <= 1'b0;            // stall-free stretch
        repeat ($urandom_range(30, 90)) @(posedge clk);
      end else begin
        n = idle_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: a result moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.compare_result(out_status, out_data, out_count);
  end

  // Send one item and hold it until accepted. Valid is lowered only when a gap
  // follows, so a back-to-back item never sees valid dropped and raised in one step.
  task automatic send_item(input logic [2:0] op, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = in_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_op(op, value, pos);
  endtask

  // Corners: empty pops, read with nothing held, no-op codes, extreme words,
  // fill to capacity, pushes when full, read of the last slot, pops at full.
  task automatic run_directed();
    send_item(OP_POP_BACK, '1, '0);
    send_item(OP_POP_FRONT, '0, '1);
    send_item(OP_READ, '0, '0);
    for (int u = OP_FIRST_UNUSED; u <= OP_LAST_UNUSED; u++)
      send_item(3'(u), $urandom, 4'($urandom));
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, '0);
    send_item(OP_PUSH_FRONT, 32'h0000_0000, '1);
    send_item(OP_READ, '0, 4'd2);                 // position equal to the count, one past the last slot
    for (int k = 0; k < DEPTH - 2; k++)
      send_item((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, '0);
    send_item(OP_PUSH_BACK, 32'h1234_5678, '0);   // full
    send_item(OP_PUSH_FRONT, 32'h8765_4321, '0);  // full
    send_item(OP_READ, '0, 4'd15);
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_POP_FRONT, '0, '0);
  endtask

  // Random traffic in segments; each segment drifts the fill level up, down
  // or holds it, and may run with no sender gaps at all.
  task automatic run_random(input int n_items);
    int                 done;
    int                 seg_left;
    int                 r;
    int                 push_pct;
    drift_t             drift;
    logic [2:0]         op;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    done     = 0;
    seg_left = 0;
    drift    = DRIFT_MIXED;
    while (done < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(15, 60);
        drift    = drift_t'($urandom_range(0, 2));
        in_calm  = ($urandom_range(0, 4) == 0);
      end
      seg_left--;
      case (drift)
        DRIFT_GROW:   push_pct = 75;
        DRIFT_SHRINK: push_pct = 25;
        default:      push_pct = 50;
      endcase
      r = $urandom_range(0, 9);
      value = (r == 0) ? '0 : (r == 1) ? '1 : VALUE_W'($urandom);
      pos = POS_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else if (r < 18) begin
        op = OP_READ;
        // mostly valid positions; the rest land anywhere in the field
        if (tracker.fill != 0 && $urandom_range(0, 3) != 0)
          pos = POS_W'($urandom_range(0, tracker.fill - 1));
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_item(op, value, pos);
      done++;
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(RANDOM_ITEMS);
    in_valid <= 1'b0;
    // wait for every owed result, then a few cycles to catch any extra one
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d items sent, %0d results checked, %0d mismatches",
             tracker.n_items, tracker.n_checked, tracker.errors);
    $display("Corners: %0d pushes when full, %0d pops when empty, %0d reads out of range, %0d no-op codes, capacity reached %0d times",
             tracker.n_full, tracker.n_empty, tracker.n_range, tracker.n_unknown,
             tracker.n_at_capacity);
    if (tracker.errors == 0) begin
      $display("tb_double_ended_queue passed");
    end else begin
      $display("tb_double_ended_queue failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== double_ended_queue.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/double_ended_queue.sv
test/tb_double_ended_queue.sv
